// ===== src/bmpr_pkg.sv =====
// Shared types and constants for the BMP RLE8/RLE4 run decoder.
// No dependencies; imported by every module of the decoder.
package bmpr_pkg;

	// register indexes on the config port
	localparam logic [1:0] REG_NIBBLE_MODE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// escape codes following a zero count byte
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	localparam logic [7:0]  NIB_MASK    = 8'h0f;
	localparam logic [12:0] COL_SAT     = 13'd8191;
	localparam logic [11:0] OUT_COL_MAX = 12'd4095;
	localparam int          FIELD_CAP   = 4096;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_SECOND = 3'd1,
		PH_ABS    = 3'd2,
		PH_PAD    = 3'd3,
		PH_DX     = 3'd4,
		PH_DY     = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] start_column;
		logic [7:0]  run_length;
		logic [7:0]  first_index;
		logic [7:0]  second_index;
		logic        end_of_image;
		logic        overrun;
	} result_t;

	// decoder settings handed from the register block to the parser
	typedef struct packed {
		logic        nibble_mode;
		logic [12:0] eff_width;
		logic [11:0] row_init;
		logic        restart;
	} dec_cfg_t;

endpackage

// ===== src/bmpr_cfg.sv =====
// Configuration registers of the RLE decoder: mode, width and height.
// Derives the clamped width and starting row; depends on bmpr_pkg.
module bmpr_cfg import bmpr_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dec_cfg_t              dec_cfg
);

	localparam int W_CAP_I = (MAX_WIDTH < FIELD_CAP) ? MAX_WIDTH : FIELD_CAP;
	localparam int H_CAP_I = (MAX_HEIGHT < FIELD_CAP) ? MAX_HEIGHT : FIELD_CAP;
	localparam logic [12:0] W_CAP = 13'(W_CAP_I);
	localparam logic [12:0] H_CAP = 13'(H_CAP_I);

	logic        nibble_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic        restart_q;
	logic [12:0] eff_h;

	// register writes; any known index restarts the parser next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_q  <= 1'b0;
			width_q   <= 13'd4096;
			height_q  <= 13'd4096;
			restart_q <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NIBBLE_MODE: begin
						nibble_q  <= cfg_data[0];
						restart_q <= 1'b1;
					end
					REG_IMAGE_WIDTH: begin
						width_q   <= cfg_data;
						restart_q <= 1'b1;
					end
					REG_IMAGE_HEIGHT: begin
						height_q  <= cfg_data;
						restart_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// clamp to the build limits and the 12-bit output fields
	always_comb begin
		eff_h                = (height_q > H_CAP) ? H_CAP : height_q;
		dec_cfg.nibble_mode  = nibble_q;
		dec_cfg.eff_width    = (width_q > W_CAP) ? W_CAP : width_q;
		dec_cfg.row_init     = (eff_h == 13'd0) ? 12'd0 : 12'(eff_h - 13'd1);
		dec_cfg.restart      = restart_q;
	end

endmodule

// ===== src/bmpr_parser.sv =====
// Byte parser of the RLE decoder: escape handling, position tracking and
// run clipping for one stream byte per cycle in which fire is high; depends on bmpr_pkg.
module bmpr_parser import bmpr_pkg::*; #(
	parameter logic [11:0] ROW_RST = 12'd4095
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dec_cfg_t   dec_cfg,
	input  logic       fire,
	input  logic [7:0] stream_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  abs_left_q, abs_left_d;
	logic        parity_q, parity_d;
	logic [12:0] col_q, col_d;
	logic [11:0] row_q, row_d;
	logic [7:0]  dx_q, dx_d;

	logic        run_en;
	logic        eob;
	logic [7:0]  r_count;
	logic [7:0]  r_hi;
	logic [7:0]  r_lo;
	logic [7:0]  nib_hi;
	logic [7:0]  nib_lo;
	logic        col_past;
	logic [12:0] room;
	logic [7:0]  r_len;
	logic        r_ov;
	logic [13:0] run_sum;
	logic [12:0] col_run;
	logic [13:0] dx_sum;
	logic [12:0] col_dx;
	logic [7:0]  abs_n;

	assign nib_hi = (stream_byte >> 4) & NIB_MASK;
	assign nib_lo = stream_byte & NIB_MASK;

	// run source: encoded pair or one literal byte
	always_comb begin
		run_en  = 1'b0;
		eob     = 1'b0;
		r_count = 8'd0;
		abs_n   = (dec_cfg.nibble_mode && abs_left_q >= 8'd2) ? 8'd2 : 8'd1;
		r_hi    = dec_cfg.nibble_mode ? nib_hi : stream_byte;
		r_lo    = dec_cfg.nibble_mode ? nib_lo : stream_byte;
		unique case (phase_q)
			PH_SECOND: begin
				if (held_q != 8'd0) begin
					run_en  = 1'b1;
					r_count = held_q;
				end else if (stream_byte == ESC_EOB) begin
					eob = 1'b1;
				end
			end
			PH_ABS: begin
				run_en  = 1'b1;
				r_count = abs_n;
			end
			default: ;
		endcase
	end

	// clip against the row width, advance by the full count
	always_comb begin
		col_past = col_q >= dec_cfg.eff_width;
		room     = dec_cfg.eff_width - col_q;
		if (col_past) begin
			r_len = 8'd0;
			r_ov  = 1'b1;
		end else begin
			r_len = ({5'd0, r_count} < room) ? r_count : room[7:0];
			r_ov  = {5'd0, r_count} > room;
		end
		run_sum = {1'b0, col_q} + {6'd0, r_count};
		col_run = (run_sum > {1'b0, COL_SAT}) ? COL_SAT : run_sum[12:0];
		dx_sum  = {1'b0, col_q} + {6'd0, dx_q};
		col_dx  = (dx_sum > {1'b0, COL_SAT}) ? COL_SAT : dx_sum[12:0];
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		abs_left_d = abs_left_q;
		parity_d   = parity_q;
		col_d      = col_q;
		row_d      = row_q;
		dx_d       = dx_q;
		unique case (phase_q)
			PH_FIRST: begin
				held_d  = stream_byte;
				phase_d = PH_SECOND;
			end
			PH_SECOND: begin
				phase_d = PH_FIRST;
				if (held_q != 8'd0) begin
					col_d = col_run;
				end else begin
					unique case (stream_byte)
						ESC_EOL: begin
							col_d = 13'd0;
							row_d = (row_q != 12'd0) ? row_q - 12'd1 : 12'd0;
						end
						ESC_EOB:   phase_d = PH_DONE;
						ESC_DELTA: phase_d = PH_DX;
						default: begin
							abs_left_d = stream_byte;
							parity_d   = 1'b0;
							phase_d    = PH_ABS;
						end
					endcase
				end
			end
			PH_ABS: begin
				parity_d   = ~parity_q;
				abs_left_d = (abs_left_q >= abs_n) ? abs_left_q - abs_n : 8'd0;
				col_d      = col_run;
				if (abs_left_d == 8'd0) begin
					phase_d = parity_d ? PH_PAD : PH_FIRST;
				end
			end
			PH_PAD: phase_d = PH_FIRST;
			PH_DX: begin
				dx_d    = stream_byte;
				phase_d = PH_DY;
			end
			PH_DY: begin
				col_d   = col_dx;
				row_d   = (row_q >= {4'd0, stream_byte}) ?
					row_q - {4'd0, stream_byte} : 12'd0;
				phase_d = PH_FIRST;
			end
			default: phase_d = PH_DONE;
		endcase
	end

	// result for this beat
	always_comb begin
		res_valid          = run_en || eob;
		res.row            = row_q;
		res.start_column   = (col_q > {1'b0, OUT_COL_MAX}) ? OUT_COL_MAX : col_q[11:0];
		res.run_length     = eob ? 8'd0 : r_len;
		res.first_index    = eob ? 8'd0 : r_hi;
		res.second_index   = eob ? 8'd0 : r_lo;
		res.end_of_image   = eob;
		res.overrun        = eob ? 1'b0 : r_ov;
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			held_q     <= 8'd0;
			abs_left_q <= 8'd0;
			parity_q   <= 1'b0;
			col_q      <= 13'd0;
			row_q      <= ROW_RST;
			dx_q       <= 8'd0;
		end else if (dec_cfg.restart) begin
			phase_q    <= PH_FIRST;
			held_q     <= 8'd0;
			abs_left_q <= 8'd0;
			parity_q   <= 1'b0;
			col_q      <= 13'd0;
			row_q      <= dec_cfg.row_init;
			dx_q       <= 8'd0;
		end else if (fire) begin
			phase_q    <= phase_d;
			held_q     <= held_d;
			abs_left_q <= abs_left_d;
			parity_q   <= parity_d;
			col_q      <= col_d;
			row_q      <= row_d;
			dx_q       <= dx_d;
		end
	end

endmodule

// ===== src/bmp_rle_decoder_top.sv =====
// BMP RLE8/RLE4 decoder: one compressed byte per cycle in, pixel run
// writes out. The decoder takes a stream byte every cycle unless stalled; a
// byte is held in an input register, parsed from there and its run (if any)
// is registered in the result register that drives the result port. The
// sustained rate is one byte per cycle when not stalled, set by the
// single parse step per byte. A full result register that is not taken
// stalls the input register and then the stream. A register write
// restarts the parser.
// Top level; depends on bmpr_pkg, bmpr_cfg and bmpr_parser.
module bmp_rle_decoder_top import bmpr_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  stream_valid,
	output logic                  stream_ready,
	input  logic [7:0]            stream_byte,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [11:0]           row,
	output logic [11:0]           start_column,
	output logic [7:0]            run_length,
	output logic [7:0]            first_index,
	output logic [7:0]            second_index,
	output logic                  end_of_image,
	output logic                  overrun
);

	localparam int H_CAP_I = (MAX_HEIGHT < FIELD_CAP) ? MAX_HEIGHT : FIELD_CAP;
	localparam logic [11:0] ROW_RST = 12'(H_CAP_I - 1);

	dec_cfg_t   dec_cfg;
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       consume;
	logic       res_valid;
	result_t    res;
	logic       out_vld_q;
	result_t    out_q;

	bmpr_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.dec_cfg  (dec_cfg)
	);

	bmpr_parser #(
		.ROW_RST(ROW_RST)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.dec_cfg    (dec_cfg),
		.fire       (consume),
		.stream_byte(byte_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	// held byte is parsed when the result register can take its beat
	// and waits out the restart cycle after a register write
	assign consume      = vld_s1 && !dec_cfg.restart && (!out_vld_q || result_ready);
	assign stream_ready = !vld_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (stream_ready) begin
			vld_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && stream_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (consume) begin
			out_vld_q <= res_valid;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid = out_vld_q;
	assign row          = out_q.row;
	assign start_column = out_q.start_column;
	assign run_length   = out_q.run_length;
	assign first_index  = out_q.first_index;
	assign second_index = out_q.second_index;
	assign end_of_image = out_q.end_of_image;
	assign overrun      = out_q.overrun;

	// end marker carries no pixels and no clip flag
	a_eoi_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_image |-> run_length == 8'd0 && !overrun)
		else $error("end marker with pixels or clip flag");

	// an unclipped run always writes at least one pixel
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !end_of_image && !overrun |-> run_length != 8'd0)
		else $error("unclipped run of zero length");

	// a stalled input beat is kept until parsed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !consume |=> vld_s1 && $stable(byte_s1))
		else $error("input register lost a stalled beat");

	// in 8-bit mode both indices of a run agree
	a_byte_mode_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !dec_cfg.nibble_mode |-> first_index == second_index)
		else $error("index mismatch in 8-bit mode");

endmodule
